[hdl/bsi_pkg.sv]
// Shared types and constants for the bubble sort core.
package bsi_pkg;

  typedef logic signed [31:0] value_t;
  typedef logic [1:0]         dir_t;

  localparam dir_t DIR_ASC  = 2'd0;
  localparam dir_t DIR_DESC = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_CMP,
    ST_WB,
    ST_ORD,
    ST_OLD,
    ST_OHOLD
  } state_t;

  typedef struct packed {
    value_t a;
    value_t b;
    logic   desc;
  } cmp_req_t;

endpackage

[hdl/bsi_if.sv]
// Valid/ready channel interfaces for array elements in and sorted elements out.
interface bsi_in_if;
  logic            valid;
  logic            ready;
  bsi_pkg::value_t item_value;
  logic            item_last;

  modport source (output valid, output item_value, output item_last, input ready);
  modport sink   (input valid, input item_value, input item_last, output ready);
endinterface

interface bsi_out_if;
  logic            valid;
  logic            ready;
  bsi_pkg::value_t sorted_value;
  logic            sorted_last;

  modport source (output valid, output sorted_value, output sorted_last, input ready);
  modport sink   (input valid, input sorted_value, input sorted_last, output ready);
endinterface

[hdl/bsi_store.sv]
// Element memory: one write port, one read port with registered read data.
module bsi_store #(
  parameter int DEPTH = 32,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  bsi_pkg::value_t wdata,
  input  logic [AW-1:0]   raddr,
  output bsi_pkg::value_t rdata
);
  import bsi_pkg::*;

  value_t mem [DEPTH];
  value_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/bsi_cmp.sv]
// Shared signed compare unit: decides whether the carried element moves past the next one.
module bsi_cmp (
  input  bsi_pkg::cmp_req_t req,
  output logic              swap
);
  import bsi_pkg::*;

  // Strict compare only, so equal elements keep their order.
  always_comb begin
    if (req.desc) begin
      swap = req.a < req.b;
    end else begin
      swap = req.a > req.b;
    end
  end

endmodule

[hdl/bsi_seq.sv]
// Sequencer: element capture, bubble passes over the store and in-order readout.
module bsi_seq #(
  parameter int MAX_ITEMS = 32,
  localparam int AW       = $clog2(MAX_ITEMS),
  localparam int CW       = $clog2(MAX_ITEMS + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  bsi_in_if.sink             in_ch,
  bsi_out_if.source          out_ch,
  input  bsi_pkg::dir_t      sort_dir,
  output logic               mem_we,
  output logic [AW-1:0]      mem_waddr,
  output bsi_pkg::value_t    mem_wdata,
  output logic [AW-1:0]      mem_raddr,
  input  bsi_pkg::value_t    mem_rdata,
  output bsi_pkg::cmp_req_t  cmp_req,
  input  logic               cmp_swap
);
  import bsi_pkg::*;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] lim_r, lim_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [AW-1:0] k_r, k_nxt;
  value_t        carry_r, carry_nxt;
  logic          desc_r, desc_nxt;
  logic          out_valid_r, out_valid_nxt;
  value_t        out_value_r, out_value_nxt;
  logic          out_last_r, out_last_nxt;

  logic [CW-1:0] pos_p2;
  logic [CW-1:0] k_p1;
  logic [CW-1:0] lim_m1;
  logic [CW-1:0] n_fin;
  logic          has_room;

  assign has_room = cnt_r < CW'(MAX_ITEMS);
  assign n_fin    = has_room ? cnt_r + CW'(1) : cnt_r;
  assign pos_p2   = CW'(pos_r) + CW'(2);
  assign k_p1     = CW'(k_r) + CW'(1);
  assign lim_m1   = lim_r - CW'(1);

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.sorted_value = out_value_r;
  assign out_ch.sorted_last  = out_last_r;

  assign cmp_req.a    = carry_r;
  assign cmp_req.b    = mem_rdata;
  assign cmp_req.desc = desc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lim_r       <= lim_nxt;
    pos_r       <= pos_nxt;
    k_r         <= k_nxt;
    carry_r     <= carry_nxt;
    desc_r      <= desc_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    lim_nxt       = lim_r;
    pos_nxt       = pos_r;
    k_nxt         = k_r;
    carry_nxt     = carry_r;
    desc_nxt      = desc_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = carry_r;
    mem_raddr     = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          // Store while there is room; drop overflow elements.
          if (has_room) begin
            mem_we    = 1'b1;
            mem_waddr = cnt_r[AW-1:0];
            mem_wdata = in_ch.item_value;
          end
          cnt_nxt = n_fin;
          if (in_ch.item_last) begin
            desc_nxt = (sort_dir == DIR_DESC);
            lim_nxt  = n_fin;
            k_nxt    = '0;
            if ((sort_dir == DIR_ASC || sort_dir == DIR_DESC) && n_fin >= CW'(2)) begin
              state_nxt = ST_FIRST;
            end else begin
              state_nxt = ST_ORD;
            end
          end
        end
      end
      ST_FIRST: begin
        carry_nxt = mem_rdata;
        mem_raddr = AW'(1);
        pos_nxt   = '0;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        // Write back the element that stays; carry the one that moves on.
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        mem_wdata = cmp_swap ? mem_rdata : carry_r;
        carry_nxt = cmp_swap ? carry_r : mem_rdata;
        if (pos_p2 < lim_r) begin
          mem_raddr = pos_p2[AW-1:0];
          pos_nxt   = pos_r + AW'(1);
        end else begin
          state_nxt = ST_WB;
        end
      end
      ST_WB: begin
        mem_we    = 1'b1;
        mem_waddr = lim_m1[AW-1:0];
        mem_wdata = carry_r;
        lim_nxt   = lim_m1;
        if (lim_m1 >= CW'(2)) begin
          state_nxt = ST_FIRST;
        end else begin
          k_nxt     = '0;
          state_nxt = ST_ORD;
        end
      end
      ST_ORD: begin
        mem_raddr = k_r;
        state_nxt = ST_OLD;
      end
      ST_OLD: begin
        out_value_nxt = mem_rdata;
        out_last_nxt  = (k_p1 == cnt_r);
        out_valid_nxt = 1'b1;
        state_nxt     = ST_OHOLD;
      end
      ST_OHOLD: begin
        if (out_ch.ready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            cnt_nxt   = '0;
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = k_r + AW'(1);
            state_nxt = ST_ORD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[hdl/bubble_sort_int_array_core.sv]
// Top level of the bubble sort core: direction register, sequencer, store and compare unit.
//
// Elements arrive one per transfer on in_ch, one per cycle while the core is idle; the
// transfer with item_last set closes the array. Up to MAX_ITEMS elements are kept, later
// ones are dropped, but their last flag still closes the array. The core then sorts the
// stored N elements in place with bubble passes, ascending for direction 0, descending
// for 1, unchanged for 2 or 3; equal elements keep their arrival order. The direction
// register is sampled when the last element transfers. One signed comparator and a single
// element memory (one write, one registered read per cycle) do all the work: a pass over
// the first L elements carries the larger (or smaller) element along to position L - 1.
// The sorted elements then leave on out_ch from an output register, one at a time: each is
// read, registered and held until the sink is ready, the final one with sorted_last set.
// in_ch is not ready from the last element's transfer until the final result transfers.
// There is no clearing pass after reset.
module bubble_sort_int_array_core #(
  parameter int MAX_ITEMS = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  bsi_in_if.sink        in_ch,
  bsi_out_if.source     out_ch,
  input  logic          cfg_wr_en,
  input  bsi_pkg::dir_t cfg_wr_data
);
  import bsi_pkg::*;

  localparam int AW = $clog2(MAX_ITEMS);

  dir_t          sort_dir_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  value_t        mem_wdata;
  logic [AW-1:0] mem_raddr;
  value_t        mem_rdata;
  cmp_req_t      cmp_req;
  logic          cmp_swap;

  // Direction register; the user must write it only while the core is idle, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sort_dir_r <= DIR_ASC;
    end else if (cfg_wr_en) begin
      sort_dir_r <= cfg_wr_data;
    end
  end

  // Sequencer: capture, bubble passes and readout.
  bsi_seq #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .sort_dir  (sort_dir_r),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .cmp_req   (cmp_req),
    .cmp_swap  (cmp_swap)
  );

  // Element store.
  bsi_store #(
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Shared comparator, reused by every step of every pass.
  bsi_cmp u_cmp (
    .req  (cmp_req),
    .swap (cmp_swap)
  );

  // Never take input while a result is pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input ready while a result is pending");

  // Closing the array stops input until results are out.
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.item_last) |=> !in_ch.ready)
    else $error("input still ready after the last element");

  // Final result transfer returns the core to idle.
  a_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.sorted_last) |=> in_ch.ready)
    else $error("core not idle after the final result");

endmodule
